// ===== design/ufcm_pkg.sv =====
// Shared types and constants for the union-find component merger.
// Depends on nothing; the engine, the top level and the checker import it.
`timescale 1ns / 1ps
`default_nettype none

package ufcm_pkg;

   localparam int NODE_W        = 10;
   localparam int CNT_W         = 11;
   localparam int SIZE_W        = 11;
   localparam int DEF_MAX_NODES = 1024;

   localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};
   localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);
   localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EDGE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_COMP,
      ST_INFO_A,
      ST_INFO_B,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              mark;
      logic [SIZE_W-1:0] size;
   } info_type;

   localparam int INFO_W = $bits(info_type);

   typedef struct packed {
      logic              accepted;
      logic              both_marked;
      logic [NODE_W-1:0] new_root;
      logic [CNT_W-1:0]  components_left;
      logic              done_res;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== design/ufcm_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing; holds the parent table and the root info table.
`timescale 1ns / 1ps
`default_nettype none

module ufcm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/ufcm_engine.sv =====
// Sequencer and datapath: parent walks with path compression, union by size, count upkeep.
// Depends on ufcm_pkg; drives the parent RAM and the root info RAM.
`timescale 1ns / 1ps
`default_nettype none

module ufcm_engine
   import ufcm_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [CNT_W-1:0]  csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_cmd,
   input  wire logic [NODE_W-1:0] req_node_a,
   input  wire logic [NODE_W-1:0] req_node_b,
   input  wire logic              req_marked,
   output logic                   emit_valid,
   input  wire logic              emit_ready,
   output rsp_word_type           emit_word,
   output logic                   par_we,
   output logic      [ADDR_W-1:0] par_waddr,
   output logic      [ADDR_W-1:0] par_wdata,
   output logic      [ADDR_W-1:0] par_raddr,
   input  wire logic [ADDR_W-1:0] par_rdata,
   output logic                   inf_we,
   output logic      [ADDR_W-1:0] inf_waddr,
   output info_type               inf_wdata,
   output logic      [ADDR_W-1:0] inf_raddr,
   input  wire info_type          inf_rdata
);

   localparam int STEP_W = $clog2(MAX_NODES + 1);
   localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_NODES);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] node_a_ff, node_a_in;
   logic [ADDR_W-1:0] node_b_ff, node_b_in;
   logic [ADDR_W-1:0] ra_ff, ra_in;
   logic [ADDR_W-1:0] rb_ff, rb_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              side_ff, side_in;
   logic              look_ff, look_in;
   logic [NODE_W-1:0] root_ff, root_in;
   logic              acc_ff, acc_in;
   logic              both_ff, both_in;
   info_type          info_a_ff, info_a_in;
   logic [CNT_W-1:0]  mc_ff, mc_in;
   logic              fin_ff, fin_in;

   logic              accept;
   logic              a_ok, b_ok, is_done;
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic [ADDR_W-1:0] start_node, walk_root;
   logic              at_root, comp_end, step_cap;
   logic              a_small;
   logic [ADDR_W-1:0] big, small_root;
   logic [SIZE_W:0]   size_sum;
   logic [CNT_W-1:0]  mc_dec;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign a_ok    = 32'(req_node_a) < MAX_NODES;
   assign b_ok    = 32'(req_node_b) < MAX_NODES;
   assign addr_a  = ADDR_W'(req_node_a);
   assign addr_b  = ADDR_W'(req_node_b);
   assign is_done = fin_ff || (mc_ff <= CNT_ONE);

   assign start_node = side_ff ? node_b_ff : node_a_ff;
   assign walk_root  = side_ff ? rb_ff : ra_ff;
   assign step_cap   = (steps_ff == STEP_LIMIT);
   assign at_root    = (par_rdata == cur_ff) || step_cap;
   assign comp_end   = (par_rdata == walk_root) || step_cap;

   assign a_small    = info_a_ff.size < inf_rdata.size;
   assign big        = a_small ? rb_ff : ra_ff;
   assign small_root = a_small ? ra_ff : rb_ff;
   assign size_sum   = {1'b0, info_a_ff.size} + {1'b0, inf_rdata.size};
   assign mc_dec     = (mc_ff == '0) ? '0 : mc_ff - CNT_ONE;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_cmd == CMD_LOAD || !a_ok) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (at_root) begin
               priority if (look_ff) begin
                  state_in = ST_EMIT;
               end else if (cur_ff != start_node) begin
                  state_in = ST_COMP;
               end else if (!side_ff) begin
                  state_in = ST_FIND;
               end else if (ra_ff == cur_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_INFO_A;
               end
            end
         end
         ST_COMP: begin
            if (comp_end) begin
               priority if (!side_ff) begin
                  state_in = ST_FIND;
               end else if (ra_ff == rb_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_INFO_A;
               end
            end
         end
         ST_INFO_A: state_in = ST_INFO_B;
         ST_INFO_B: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cur_in    = cur_ff;
      node_a_in = node_a_ff;
      node_b_in = node_b_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      steps_in  = steps_ff;
      side_in   = side_ff;
      look_in   = look_ff;
      root_in   = root_ff;
      acc_in    = acc_ff;
      both_in   = both_ff;
      info_a_in = info_a_ff;
      mc_in     = mc_ff;
      fin_in    = fin_ff;

      par_we    = 1'b0;
      par_waddr = cur_ff;
      par_wdata = walk_root;
      par_raddr = cur_ff;
      inf_we    = 1'b0;
      inf_waddr = big;
      inf_wdata = info_a_ff;
      inf_raddr = ra_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               node_a_in = addr_a;
               node_b_in = addr_b;
               cur_in    = addr_a;
               par_raddr = addr_a;
               steps_in  = '0;
               side_in   = 1'b0;
               look_in   = !b_ok || is_done;
               acc_in    = 1'b0;
               both_in   = 1'b0;
               root_in   = '0;
               if (req_cmd == CMD_LOAD) begin
                  root_in = req_node_a;
                  if (a_ok) begin
                     par_we         = 1'b1;
                     par_waddr      = addr_a;
                     par_wdata      = addr_a;
                     inf_we         = 1'b1;
                     inf_waddr      = addr_a;
                     inf_wdata.mark = req_marked;
                     inf_wdata.size = SIZE_ONE;
                  end
               end
            end
         end
         ST_FIND: begin
            if (at_root) begin
               steps_in = '0;
               if (!side_ff) begin
                  ra_in   = cur_ff;
                  root_in = NODE_W'(cur_ff);
               end else begin
                  rb_in = cur_ff;
               end
               priority if (look_ff) begin
                  cur_in = cur_ff;
               end else if (cur_ff != start_node) begin
                  cur_in    = start_node;
                  par_raddr = start_node;
               end else if (!side_ff) begin
                  cur_in    = node_b_ff;
                  par_raddr = node_b_ff;
                  side_in   = 1'b1;
               end else begin
                  inf_raddr = ra_ff;
               end
            end else begin
               cur_in    = par_rdata;
               par_raddr = par_rdata;
               steps_in  = steps_ff + STEP_W'(1);
            end
         end
         ST_COMP: begin
            par_we    = 1'b1;
            par_waddr = cur_ff;
            par_wdata = walk_root;
            if (comp_end) begin
               steps_in = '0;
               if (!side_ff) begin
                  cur_in    = node_b_ff;
                  par_raddr = node_b_ff;
                  side_in   = 1'b1;
               end else begin
                  inf_raddr = ra_ff;
               end
            end else begin
               cur_in    = par_rdata;
               par_raddr = par_rdata;
               steps_in  = steps_ff + STEP_W'(1);
            end
         end
         ST_INFO_A: begin
            inf_raddr = rb_ff;
            info_a_in = inf_rdata;
         end
         ST_INFO_B: begin
            par_we         = 1'b1;
            par_waddr      = small_root;
            par_wdata      = big;
            inf_we         = 1'b1;
            inf_waddr      = big;
            inf_wdata.mark = info_a_ff.mark || inf_rdata.mark;
            inf_wdata.size = size_sum[SIZE_W] ? SIZE_SAT : size_sum[SIZE_W-1:0];
            acc_in         = 1'b1;
            root_in        = NODE_W'(big);
            if (info_a_ff.mark && inf_rdata.mark) begin
               both_in = 1'b1;
               mc_in   = mc_dec;
               if (mc_dec <= CNT_ONE) begin
                  fin_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            cur_in = cur_ff;
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase

      if (csr_we) begin
         mc_in  = csr_wdata;
         fin_in = 1'b0;
      end
   end

   always_comb begin
      emit_valid                = (state_ff == ST_EMIT);
      emit_word.accepted        = acc_ff;
      emit_word.both_marked     = both_ff;
      emit_word.new_root        = root_ff;
      emit_word.components_left = mc_ff;
      emit_word.done_res        = is_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mc_ff    <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         mc_ff    <= mc_in;
         fin_ff   <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      node_a_ff <= node_a_in;
      node_b_ff <= node_b_in;
      ra_ff     <= ra_in;
      rb_ff     <= rb_in;
      steps_ff  <= steps_in;
      side_ff   <= side_in;
      look_ff   <= look_in;
      root_ff   <= root_in;
      acc_ff    <= acc_in;
      both_ff   <= both_in;
      info_a_ff <= info_a_in;
   end

endmodule

`default_nettype wire

// ===== design/union_find_component_merger.sv =====
// Union-find component merger: the top level, joining engine, tables and result register.
// Depends on ufcm_pkg, ufcm_ram and ufcm_engine.
//
// A load word (cmd 0) makes node_a a root of size 1 with the given mark; an edge word
// (cmd 1) finds both roots, compresses both walked paths and links the smaller tree
// under the larger one, ORing marks and lowering the marked-component count when both
// sides were marked. One word is in flight at a time; the result register lets the
// next request be taken while a result waits. Each walk steps through the parent
// table one node at a time, and compression points every node on a walked path
// straight at its root; an edge that is ignored because the block is done, or
// because node_b is out of range, walks node_a's path once and compresses nothing.
// There is no clearing pass: tables hold garbage until nodes are loaded.
`timescale 1ns / 1ps
`default_nettype none

module union_find_component_merger
   import ufcm_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [CNT_W-1:0]  csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_cmd,
   input  wire logic [NODE_W-1:0] req_node_a,
   input  wire logic [NODE_W-1:0] req_node_b,
   input  wire logic              req_marked,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_accepted,
   output logic                   rsp_both_marked,
   output logic      [NODE_W-1:0] rsp_new_root,
   output logic      [CNT_W-1:0]  rsp_components_left,
   output logic                   rsp_done_res
);

   localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

   logic              par_we;
   logic [ADDR_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
   logic              inf_we;
   logic [ADDR_W-1:0] inf_waddr, inf_raddr;
   info_type          inf_wdata, inf_rdata;

   logic              emit_valid, emit_ready;
   rsp_word_type      emit_word;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff;

   ufcm_ram #(
      .WIDTH  (ADDR_W),
      .DEPTH  (MAX_NODES),
      .ADDR_W (ADDR_W)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   ufcm_ram #(
      .WIDTH  (INFO_W),
      .DEPTH  (MAX_NODES),
      .ADDR_W (ADDR_W)
   ) u_info_ram (
      .clock   (clock),
      .wr_en   (inf_we),
      .wr_addr (inf_waddr),
      .wr_data (inf_wdata),
      .rd_addr (inf_raddr),
      .rd_data (inf_rdata)
   );

   ufcm_engine #(
      .MAX_NODES (MAX_NODES),
      .ADDR_W    (ADDR_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_node_a (req_node_a),
      .req_node_b (req_node_b),
      .req_marked (req_marked),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .emit_word  (emit_word),
      .par_we     (par_we),
      .par_waddr  (par_waddr),
      .par_wdata  (par_wdata),
      .par_raddr  (par_raddr),
      .par_rdata  (par_rdata),
      .inf_we     (inf_we),
      .inf_waddr  (inf_waddr),
      .inf_wdata  (inf_wdata),
      .inf_raddr  (inf_raddr),
      .inf_rdata  (inf_rdata)
   );

   // hold the result word until taken
   assign emit_ready   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (emit_valid && emit_ready) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid && emit_ready) begin
         rsp_word_ff <= emit_word;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_word_ff.accepted;
   assign rsp_both_marked     = rsp_word_ff.both_marked;
   assign rsp_new_root        = rsp_word_ff.new_root;
   assign rsp_components_left = rsp_word_ff.components_left;
   assign rsp_done_res        = rsp_word_ff.done_res;

endmodule

`default_nettype wire

// ===== design/ufcm_checker.sv =====
// Port-level checks for the union-find component merger, bound to the top level.
// Depends on ufcm_pkg and union_find_component_merger.
`timescale 1ns / 1ps
`default_nettype none

module ufcm_checker
   import ufcm_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic              rsp_accepted,
   input wire logic              rsp_both_marked,
   input wire logic [NODE_W-1:0] rsp_new_root,
   input wire logic [CNT_W-1:0]  rsp_components_left,
   input wire logic              rsp_done_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_accepted) && $stable(rsp_both_marked)
         && $stable(rsp_new_root) && $stable(rsp_components_left) && $stable(rsp_done_res))
      else $error("stalled result word changed");

   a_done_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_done_res == (rsp_components_left <= CNT_W'(1)))
      else $error("done flag disagrees with component count");

   a_both_join: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_both_marked |-> rsp_accepted)
      else $error("both-marked reported without a join");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in flight");

endmodule

bind union_find_component_merger ufcm_checker u_ufcm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_accepted        (rsp_accepted),
   .rsp_both_marked     (rsp_both_marked),
   .rsp_new_root        (rsp_new_root),
   .rsp_components_left (rsp_components_left),
   .rsp_done_res        (rsp_done_res)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for union_find_component_merger: drives load and edge words,
// predicts every result with its own union-find tables and checks each field.
// Depends on ufcm_pkg and the design files; reads and writes no files.

module tb_top;
   import ufcm_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int HOLD_CYCLES    = 400;
   localparam int TARGET_ITEMS   = 1900;

   class merge_tracker;
      logic [NODE_W-1:0] parent_of [DEF_MAX_NODES];
      logic [SIZE_W-1:0] tree_size [DEF_MAX_NODES];
      logic              tree_mark [DEF_MAX_NODES];
      logic [CNT_W-1:0]  marked_left;
      bit                finished;
      rsp_word_type      expected_merges [$];
      int                mismatches;

      function new();
         foreach (parent_of[i]) begin
            parent_of[i] = '0;
            tree_size[i] = '0;
            tree_mark[i] = 1'b0;
         end
         marked_left = '0;
         finished    = 0;
         mismatches  = 0;
      endfunction

      task report(input string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         mismatches++;
      endtask

      function int pending();
         return expected_merges.size();
      endfunction

      function bit merging_done();
         return finished || (marked_left <= CNT_ONE);
      endfunction

      function void set_robot_count(input logic [CNT_W-1:0] value);
         marked_left = value;
         finished    = 0;
      endfunction

      function logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] node);
         int steps;
         steps = 0;
         while (parent_of[node] != node && steps < DEF_MAX_NODES) begin
            node = parent_of[node];
            steps++;
         end
         return node;
      endfunction

      function logic [NODE_W-1:0] flatten_to_root(input logic [NODE_W-1:0] node);
         logic [NODE_W-1:0] top;
         logic [NODE_W-1:0] nxt;
         int                steps;
         top   = root_of(node);
         steps = 0;
         while (node != top && steps < DEF_MAX_NODES) begin
            nxt             = parent_of[node];
            parent_of[node] = top;
            node            = nxt;
            steps++;
         end
         return top;
      endfunction

      function void note_word(input cmd_type cmd, input logic [NODE_W-1:0] node_a,
                              input logic [NODE_W-1:0] node_b, input logic marked);
         rsp_word_type      want;
         logic [NODE_W-1:0] ra;
         logic [NODE_W-1:0] rb;
         logic [NODE_W-1:0] keep;
         logic [NODE_W-1:0] lesser;
         logic [SIZE_W:0]   total;
         logic              ma;
         logic              mb;
         want = '0;
         if (cmd == CMD_LOAD) begin
            parent_of[node_a] = node_a;
            tree_size[node_a] = SIZE_ONE;
            tree_mark[node_a] = marked;
            want.new_root     = node_a;
         end else if (merging_done()) begin
            want.new_root = root_of(node_a);
         end else begin
            ra            = flatten_to_root(node_a);
            rb            = flatten_to_root(node_b);
            want.new_root = ra;
            if (ra != rb) begin
               ma     = tree_mark[ra];
               mb     = tree_mark[rb];
               keep   = ra;
               lesser = rb;
               if (tree_size[ra] < tree_size[rb]) begin
                  keep   = rb;
                  lesser = ra;
               end
               parent_of[lesser] = keep;
               total             = tree_size[keep] + tree_size[lesser];
               tree_size[keep]   = (total > SIZE_SAT) ? SIZE_SAT : total[SIZE_W-1:0];
               tree_mark[keep]   = ma | mb;
               want.accepted     = 1'b1;
               want.new_root     = keep;
               if (ma && mb) begin
                  want.both_marked = 1'b1;
                  if (marked_left != '0) marked_left = marked_left - CNT_ONE;
                  if (marked_left <= CNT_ONE) finished = 1;
               end
            end
         end
         want.components_left = marked_left;
         want.done_res        = merging_done();
         expected_merges.insert(expected_merges.size(), want);
      endfunction

      task check_result(input rsp_word_type got);
         rsp_word_type want;
         if (expected_merges.size() == 0) begin
            report($sformatf("result %h arrived with nothing expected", got));
            return;
         end
         want = expected_merges.pop_front();
         if (got.accepted !== want.accepted)
            report($sformatf("accepted %b, expected %b", got.accepted, want.accepted));
         if (got.both_marked !== want.both_marked)
            report($sformatf("both_marked %b, expected %b", got.both_marked,
                             want.both_marked));
         if (got.new_root !== want.new_root)
            report($sformatf("new_root %0d, expected %0d", got.new_root, want.new_root));
         if (got.components_left !== want.components_left)
            report($sformatf("components_left %0d, expected %0d", got.components_left,
                             want.components_left));
         if (got.done_res !== want.done_res)
            report($sformatf("done_res %b, expected %b", got.done_res, want.done_res));
      endtask
   endclass

   logic              clock;
   logic              reset     = 1'b1;
   logic              csr_we    = 1'b0;
   logic [CNT_W-1:0]  csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   cmd_type           req_cmd   = CMD_LOAD;
   logic [NODE_W-1:0] req_node_a = '0;
   logic [NODE_W-1:0] req_node_b = '0;
   logic              req_marked = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   logic              rsp_accepted;
   logic              rsp_both_marked;
   logic [NODE_W-1:0] rsp_new_root;
   logic [CNT_W-1:0]  rsp_components_left;
   logic              rsp_done_res;
   rsp_word_type      rsp_word;

   merge_tracker      sb = new();
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   int                counted_items  = 0;
   bit                hold_request   = 0;
   bit                hold_served    = 0;
   int                hold_left      = 0;
   int                quiet_cycles   = 0;
   bit                is_loaded [DEF_MAX_NODES];
   logic [NODE_W-1:0] loaded_nodes [$];

   assign rsp_word = {rsp_accepted, rsp_both_marked, rsp_new_root, rsp_components_left,
                      rsp_done_res};

   union_find_component_merger u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_node_a          (req_node_a),
      .req_node_b          (req_node_b),
      .req_marked          (req_marked),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_both_marked     (rsp_both_marked),
      .rsp_new_root        (rsp_new_root),
      .rsp_components_left (rsp_components_left),
      .rsp_done_res        (rsp_done_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // check results, then stall at random or hold off for a long stretch
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_word);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request && !hold_served) begin
         hold_served = 1;
         hold_left   = HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no word moved for %0d cycles", $time, quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct  = 33;
            recv_stall_pct = 80;
         end
         1: begin
            send_idle_pct  = 80;
            recv_stall_pct = 33;
         end
         default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   task automatic send_word(input cmd_type cmd, input logic [NODE_W-1:0] node_a,
                            input logic [NODE_W-1:0] node_b, input logic marked);
      bit ignored;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_node_a <= node_a;
      req_node_b <= node_b;
      req_marked <= marked;
      do @(posedge clock); while (req_stall);
      ignored = (cmd == CMD_EDGE) && sb.merging_done();
      if (!ignored) counted_items++;
      sb.note_word(cmd, node_a, node_b, marked);
      if (cmd == CMD_LOAD && !is_loaded[node_a]) begin
         is_loaded[node_a] = 1;
         loaded_nodes.insert(loaded_nodes.size(), node_a);
      end
   endtask

   // drop valid and wait until every expected word has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_robot_count(input logic [CNT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_robot_count(value);
   endtask

   task automatic directed_part();
      write_robot_count(CNT_W'(3));
      send_word(CMD_LOAD, 10'd0, 10'd1023, 1'b1);
      send_word(CMD_LOAD, 10'd1023, 10'd0, 1'b1);
      send_word(CMD_LOAD, 10'd512, 10'd341, 1'b0);
      send_word(CMD_LOAD, 10'd5, 10'd682, 1'b1);
      send_word(CMD_LOAD, 10'd6, 10'd1023, 1'b0);
      send_word(CMD_EDGE, 10'd0, 10'd1023, 1'b0);
      send_word(CMD_EDGE, 10'd1023, 10'd0, 1'b1);
      send_word(CMD_EDGE, 10'd0, 10'd0, 1'b0);
      send_word(CMD_EDGE, 10'd512, 10'd0, 1'b0);
      send_word(CMD_EDGE, 10'd6, 10'd512, 1'b1);
      send_word(CMD_EDGE, 10'd5, 10'd6, 1'b0);
      send_word(CMD_EDGE, 10'd5, 10'd1023, 1'b0);
      send_word(CMD_LOAD, 10'd7, 10'd0, 1'b1);
      send_word(CMD_EDGE, 10'd7, 10'd0, 1'b0);
      wait_drain();
      write_robot_count(CNT_W'(DEF_MAX_NODES));
      send_word(CMD_EDGE, 10'd7, 10'd0, 1'b0);
      send_word(CMD_LOAD, 10'd1023, 10'd1023, 1'b0);
      send_word(CMD_EDGE, 10'd1023, 10'd5, 1'b1);
      send_word(CMD_EDGE, 10'd6, 10'd1023, 1'b0);
      wait_drain();
      write_robot_count('0);
      send_word(CMD_EDGE, 10'd512, 10'd6, 1'b1);
      send_word(CMD_LOAD, 10'd8, 10'd8, 1'b0);
   endtask

   task automatic run_phase(input int phase_no);
      logic [NODE_W-1:0] pool [$];
      bit                marks [$];
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [CNT_W-1:0]  count_cfg;
      int                pool_n;
      int                mark_pct;
      int                n_marked;
      int                budget;
      int                ignored;
      int                pick;
      pool_n   = ($urandom_range(7) == 0) ? $urandom_range(150, 300) : $urandom_range(3, 40);
      mark_pct = $urandom_range(10, 90);
      n_marked = 0;
      for (int i = 0; i < pool_n; i++) begin
         pool.insert(pool.size(), NODE_W'($urandom_range(DEF_MAX_NODES - 1)));
         marks.insert(marks.size(), $urandom_range(99) < mark_pct);
         n_marked += marks[i];
      end
      case (phase_no % 6)
         0:       count_cfg = '0;
         1:       count_cfg = CNT_W'(DEF_MAX_NODES);
         2:       count_cfg = CNT_W'(1);
         3:       count_cfg = CNT_W'(2);
         default: count_cfg = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(DEF_MAX_NODES))
                                                        : CNT_W'(n_marked);
      endcase
      wait_drain();
      write_robot_count(count_cfg);
      for (int i = 0; i < pool_n; i++)
         send_word(CMD_LOAD, pool[i], NODE_W'($urandom_range(DEF_MAX_NODES - 1)), marks[i]);
      budget  = $urandom_range(80, 200);
      ignored = 0;
      for (int n = 0; n < budget && ignored < 6; n++) begin
         if (phase_no == 1 && n == budget / 2) hold_request = 1;
         if (phase_no == 7 && n == budget / 2) wait_drain();
         pick   = $urandom_range(99);
         node_a = pool[$urandom_range(pool.size() - 1)];
         node_b = pool[$urandom_range(pool.size() - 1)];
         if (pick < 8) begin
            if (pick < 4) begin
               node_a = NODE_W'($urandom_range(DEF_MAX_NODES - 1));
               pool.insert(pool.size(), node_a);
            end
            send_word(CMD_LOAD, node_a, node_b, 1'($urandom_range(1)));
         end else begin
            if (pick < 16) node_a = loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
            if (sb.merging_done()) ignored++;
            send_word(CMD_EDGE, node_a, node_b, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      int phase_no;
      foreach (is_loaded[i]) is_loaded[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);
      directed_part();
      phase_no = 0;
      while (counted_items < TARGET_ITEMS) begin
         set_idling(counted_items * 3 / TARGET_ITEMS);
         run_phase(phase_no);
         phase_no++;
      end
      wait_drain();
      repeat (50) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
